>>> sv/pmp_pkg.sv
`timescale 1ns / 1ps

package pmp_pkg;

	localparam logic [3:0] PH_START      = 4'd0;
	localparam logic [3:0] PH_QUOTED     = 4'd1;
	localparam logic [3:0] PH_QUOTE_SEEN = 4'd2;
	localparam logic [3:0] PH_LABEL      = 4'd3;
	localparam logic [3:0] PH_VALUE      = 4'd4;
	localparam logic [3:0] PH_UNIT       = 4'd5;
	localparam logic [3:0] PH_WARN       = 4'd6;
	localparam logic [3:0] PH_CRIT       = 4'd7;
	localparam logic [3:0] PH_MIN        = 4'd8;
	localparam logic [3:0] PH_MAX        = 4'd9;
	localparam logic [3:0] PH_ERROR      = 4'd10;

	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_EMIT  = 2'd1;
	localparam logic [1:0] EV_DROP  = 2'd2;
	localparam logic [1:0] EV_ERROR = 2'd3;

	localparam logic [2:0] TAG_NONE  = 3'd0;
	localparam logic [2:0] TAG_LABEL = 3'd1;
	localparam logic [2:0] TAG_VALUE = 3'd2;
	localparam logic [2:0] TAG_UNIT  = 3'd3;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h27;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_SEMI  = 8'h3b;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} pmp_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] field_tag;
		logic       field_start;
		logic [2:0] fields_given;
		logic [1:0] metric_event;
		logic       out_last;
	} pmp_out_t;

	typedef struct packed {
		logic [3:0] phase;
		logic       label_has_equals;
		logic       label_nonempty;
		logic       value_nonempty;
		logic       unit_seen;
		logic       thr_nonempty;
	} pmp_state_t;

	localparam pmp_state_t PMP_STATE_RESET = '{
		phase: PH_START,
		label_has_equals: 1'b0,
		label_nonempty: 1'b0,
		value_nonempty: 1'b0,
		unit_seen: 1'b0,
		thr_nonempty: 1'b0
	};

endpackage

>>> sv/pmp_step.sv
`timescale 1ns / 1ps

module pmp_step import pmp_pkg::*; (
	input  pmp_state_t cur,
	input  logic [7:0] chr,
	output pmp_state_t nxt,
	output pmp_out_t   res
);

	logic is_ws;
	logic is_num;
	logic [2:0] given;

	assign is_ws = (chr == CH_SPACE) || (chr >= 8'd9 && chr <= 8'd13);
	assign is_num = (chr >= 8'h30 && chr <= 8'h39) || chr == 8'h2b || chr == 8'h2d
		|| chr == 8'h2c || chr == 8'h2e;
	assign given = 3'(cur.phase - 4'd2);

	always_comb begin
		nxt = cur;
		res = '0;
		unique case (cur.phase) inside
			PH_START: begin
				if (chr == CH_QUOTE) begin
					nxt.label_has_equals = 1'b0;
					nxt.label_nonempty = 1'b0;
					nxt.phase = PH_QUOTED;
				end else if (chr == CH_EQ) begin
					res.metric_event = EV_ERROR;
					nxt.phase = PH_ERROR;
				end else if (!is_ws) begin
					nxt.label_has_equals = 1'b0;
					nxt.label_nonempty = 1'b1;
					res.out_byte = chr;
					res.field_tag = TAG_LABEL;
					res.field_start = 1'b1;
					nxt.phase = PH_LABEL;
				end
			end
			PH_QUOTED: begin
				if (chr == CH_QUOTE) begin
					nxt.phase = PH_QUOTE_SEEN;
				end else begin
					res.out_byte = chr;
					res.field_tag = TAG_LABEL;
					res.field_start = !cur.label_nonempty;
					nxt.label_nonempty = 1'b1;
					if (chr == CH_EQ) begin
						nxt.label_has_equals = 1'b1;
					end
				end
			end
			PH_QUOTE_SEEN: begin
				if (chr == CH_QUOTE) begin
					res.out_byte = chr;
					res.field_tag = TAG_LABEL;
					res.field_start = !cur.label_nonempty;
					nxt.label_nonempty = 1'b1;
					nxt.phase = PH_QUOTED;
				end else if (chr == CH_EQ && cur.label_nonempty) begin
					nxt.value_nonempty = 1'b0;
					nxt.unit_seen = 1'b0;
					nxt.phase = PH_VALUE;
				end else begin
					res.metric_event = EV_ERROR;
					nxt.phase = PH_ERROR;
				end
			end
			PH_LABEL: begin
				if (chr == CH_QUOTE || is_ws) begin
					res.metric_event = EV_ERROR;
					nxt.phase = PH_ERROR;
				end else if (chr == CH_EQ) begin
					nxt.value_nonempty = 1'b0;
					nxt.unit_seen = 1'b0;
					nxt.phase = PH_VALUE;
				end else begin
					res.out_byte = chr;
					res.field_tag = TAG_LABEL;
				end
			end
			PH_VALUE: begin
				if (is_num) begin
					res.out_byte = chr;
					res.field_tag = TAG_VALUE;
					res.field_start = !cur.value_nonempty;
					nxt.value_nonempty = 1'b1;
				end else if (!cur.value_nonempty) begin
					res.metric_event = EV_ERROR;
					nxt.phase = PH_ERROR;
				end else if (chr == CH_SEMI) begin
					nxt.unit_seen = 1'b0;
					nxt.thr_nonempty = 1'b0;
					nxt.phase = PH_WARN;
				end else if (is_ws) begin
					if (cur.label_has_equals) begin
						res.metric_event = EV_DROP;
					end else begin
						res.metric_event = EV_EMIT;
						res.fields_given = given;
					end
					nxt.phase = PH_START;
				end else begin
					nxt.unit_seen = 1'b1;
					res.out_byte = chr;
					res.field_tag = TAG_UNIT;
					res.field_start = 1'b1;
					nxt.phase = PH_UNIT;
				end
			end
			PH_UNIT, PH_WARN, PH_CRIT, PH_MIN, PH_MAX: begin
				if (chr == CH_SEMI) begin
					if (cur.phase == PH_MAX) begin
						res.metric_event = EV_ERROR;
						nxt.phase = PH_ERROR;
					end else begin
						nxt.thr_nonempty = 1'b0;
						nxt.phase = (cur.phase == PH_UNIT) ? PH_WARN : cur.phase + 4'd1;
					end
				end else if (is_ws) begin
					if (cur.label_has_equals) begin
						res.metric_event = EV_DROP;
					end else begin
						res.metric_event = EV_EMIT;
						res.fields_given = given;
					end
					nxt.phase = PH_START;
				end else if (cur.phase == PH_UNIT) begin
					res.out_byte = chr;
					res.field_tag = TAG_UNIT;
				end else begin
					res.out_byte = chr;
					res.field_tag = given;
					res.field_start = !cur.thr_nonempty;
					nxt.thr_nonempty = 1'b1;
				end
			end
			default: begin
				if (is_ws) begin
					nxt.phase = PH_START;
				end
			end
		endcase
	end

endmodule

>>> sv/perfdata_metric_parser_unit.sv
`timescale 1ns / 1ps

// channel | signals                      | word
// input   | in_valid, in_ready, in_data  | pmp_in_t: one text byte and last mark
// output  | out_valid, out_ready, out_data | pmp_out_t: tagged byte and metric event
//
// one word per clock unless the output stalls; each result is registered from its word
// the parse state and the result register update in the same cycle, the
// implied space after a last word is evaluated in that same cycle
// reset returns to the start phase with no result pending
// in_ready is high whenever the result register is empty or being taken

module perfdata_metric_parser_unit import pmp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  pmp_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output pmp_out_t out_data
);

	pmp_state_t state_q;
	pmp_state_t mid_state;
	pmp_state_t end_state;
	pmp_out_t   byte_res;
	pmp_out_t   space_res;
	pmp_out_t   res;
	pmp_out_t   res_q;
	logic       valid_q;
	logic       accept;

	pmp_step u_byte (
		.cur(state_q),
		.chr(in_data.in_byte),
		.nxt(mid_state),
		.res(byte_res)
	);

	// implied space after the last word
	pmp_step u_space (
		.cur(mid_state),
		.chr(CH_SPACE),
		.nxt(end_state),
		.res(space_res)
	);

	assign in_ready = !valid_q || out_ready;
	assign accept = in_valid && in_ready;

	always_comb begin
		res = byte_res;
		res.out_last = in_data.in_last;
		if (in_data.in_last && byte_res.metric_event == EV_NONE) begin
			res.metric_event = space_res.metric_event;
			res.fields_given = space_res.fields_given;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PMP_STATE_RESET;
			valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= in_data.in_last ? PMP_STATE_RESET : mid_state;
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_data = res_q;

	// the end state of the implied space is discarded because a new text restarts from reset
	logic unused_end;
	assign unused_end = ^end_state;

endmodule
